### hdl/msum_pkg.sv
`timescale 1ns / 1ps
package msum_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned BEST_W = 47;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [SUM_W:0]    wide_sum_t;
  typedef logic [BEST_W-1:0]        best_t;

  // Largest representable running sum; larger sums clamp here.
  localparam sum_t SUM_MAX = 48'sh7FFF_FFFF_FFFF;

  // One input beat held between the input register and the core.
  typedef struct packed {
    logic  valid;
    logic  is_last;
    elem_t element;
  } msum_beat_t;

endpackage

### hdl/msum_if.sv
`timescale 1ns / 1ps
interface msum_in_if
  import msum_pkg::*;
();
  logic  valid;
  logic  ready;
  elem_t element;
  logic  is_last;

  modport source (output valid, output element, output is_last, input ready);
  modport sink   (input valid, input element, input is_last, output ready);
endinterface

interface msum_out_if
  import msum_pkg::*;
();
  logic  valid;
  logic  ready;
  best_t best_sum;

  modport source (output valid, output best_sum, input ready);
  modport sink   (input valid, input best_sum, output ready);
endinterface

### hdl/msum_in_stage.sv
`timescale 1ns / 1ps
module msum_in_stage
  import msum_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  elem_t      in_element,
  input  logic       in_is_last,
  input  logic       core_take,
  output msum_beat_t beat
);

  msum_beat_t beat_r;
  msum_beat_t beat_nxt;

  // Free when empty or when the held beat moves on this cycle.
  assign in_ready = !beat_r.valid || core_take;
  assign beat     = beat_r;

  always_comb begin
    beat_nxt = beat_r;
    if (in_valid && in_ready) begin
      beat_nxt.valid   = 1'b1;
      beat_nxt.is_last = in_is_last;
      beat_nxt.element = in_element;
    end else if (core_take) begin
      beat_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.is_last <= beat_nxt.is_last;
    beat_r.element <= beat_nxt.element;
  end

  a_take_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    core_take |-> beat_r.valid)
    else $error("core took a beat from an empty input register");

  a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> beat_r.valid && !core_take)
    else $error("input stalled without a pending beat");

  a_held_beat_kept: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r.valid && !core_take |=> beat_r.valid && $stable(beat_r.element))
    else $error("pending beat lost or changed");

endmodule

### hdl/msum_core.sv
`timescale 1ns / 1ps
module msum_core
  import msum_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  msum_beat_t beat,
  output logic       core_take,
  output logic       out_valid,
  input  logic       out_ready,
  output best_t      out_best_sum
);

  sum_t  prev_r, prev_nxt;
  sum_t  best_r, best_nxt;
  logic  seen_r, seen_nxt;
  logic  out_valid_r, out_valid_nxt;
  best_t out_data_r, out_data_nxt;

  sum_t      x_ext;
  wide_sum_t raw_sum;
  sum_t      ext;
  sum_t      best_upd;

  // A last beat needs the result slot; other beats always move.
  assign core_take = beat.valid && (!beat.is_last || !out_valid_r || out_ready);

  assign out_valid    = out_valid_r;
  assign out_best_sum = out_data_r;

  always_comb begin
    x_ext   = sum_t'(beat.element);
    raw_sum = wide_sum_t'(prev_r) + wide_sum_t'(x_ext);
    ext     = (raw_sum > wide_sum_t'(SUM_MAX)) ? SUM_MAX : raw_sum[SUM_W-1:0];

    prev_nxt      = prev_r;
    best_nxt      = best_r;
    seen_nxt      = seen_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    best_upd      = best_r;

    if (core_take) begin
      if (seen_r) begin
        best_upd = (ext > best_r) ? ext : best_r;
        prev_nxt = (ext > x_ext) ? ext : x_ext;
      end else begin
        prev_nxt = x_ext;
      end
      best_nxt = best_upd;
      seen_nxt = 1'b1;
      if (beat.is_last) begin
        out_data_nxt  = best_upd[BEST_W-1:0];
        out_valid_nxt = 1'b1;
        // Clear the running state for the next array.
        prev_nxt = '0;
        best_nxt = '0;
        seen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      best_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      best_r      <= best_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  a_best_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !best_r[SUM_W-1])
    else $error("running best went negative");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    core_take && beat.is_last |=> !seen_r && best_r == '0 && out_valid_r)
    else $error("last beat did not clear state and post a result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(core_take && beat.is_last))
    else $error("result posted without a last beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(core_take && beat.is_last))
    else $error("pending result overwritten");

endmodule

### hdl/max_subarray_sum_min_len2.sv
`timescale 1ns / 1ps
// Path: a last element's beat passes the input register, then the result register.
// Throughput: one element per cycle; a last element waits only while a previous
//   result is still unclaimed, set by the single result register.
// Reset: synchronous active-low rst_n clears the valid flags and running sums,
//   so the first beat after reset starts a fresh array.
module max_subarray_sum_min_len2
  import msum_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  msum_in_if.sink    in_ch,
  msum_out_if.source out_ch
);

  // Beat held in the input register, and the core's pull on it.
  msum_beat_t beat;
  logic       core_take;

  // Input register: holds one beat; upstream ready still follows the result stall.
  msum_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_element (in_ch.element),
    .in_is_last (in_ch.is_last),
    .core_take  (core_take),
    .beat       (beat)
  );

  // Running sums: extend the best run ending at the previous element by the
  // new one, keep the best extension seen (floored at zero), post it on the last beat.
  msum_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (beat),
    .core_take    (core_take),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_best_sum (out_ch.best_sum)
  );

endmodule
